// File: sv/mcop_pkg.sv
// Shared types and constants for the Monte Carlo option pricer.
package mcop_pkg;

    localparam int SUM_W      = 36;
    localparam int SAMPLE_W   = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;
    localparam int RED_W      = 63;
    localparam int TERM_W     = 61;
    localparam int EXP_W      = 62;
    localparam int ACC_W      = 121;

    // ln(2) in Q56
    localparam logic [55:0] LN2_Q56 = 56'hB17217F7D1CF7A;
    localparam logic [4:0]  TAYLOR_TERMS = 5'd24;

    localparam logic signed [37:0] SUM_MAX = 38'sd34359738367;
    localparam logic signed [37:0] SUM_MIN = -38'sd34359738368;

    typedef enum logic [2:0] {
        CFG_SPOT   = 3'd0,
        CFG_STRIKE = 3'd1,
        CFG_DRIFT  = 3'd2,
        CFG_DIFF   = 3'd3,
        CFG_DISC   = 3'd4,
        CFG_STEPS  = 3'd5,
        CFG_PATHS  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0]        spot;
        logic [31:0]        strike;
        logic signed [31:0] drift;
        logic [30:0]        diffusion;
        logic [31:0]        discount;
        logic [10:0]        step_count;
        logic [20:0]        path_count;
    } t_cfg;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RED   = 9'b000000010,
        ST_MUL   = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_PRICE = 9'b000010000,
        ST_SHIFT = 9'b000100000,
        ST_PAY   = 9'b001000000,
        ST_AVG   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_back_state;

endpackage

// File: sv/mcop_fifo.sv
// Small queue of finished log-return sums between front and back.
module mcop_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic signed [mcop_pkg::SUM_W-1:0] i_data,
    input  logic                            i_pop,
    output logic signed [mcop_pkg::SUM_W-1:0] o_data,
    output logic                            o_empty,
    output logic [mcop_pkg::FIFO_CW-1:0]    o_count
);
    import mcop_pkg::*;

    logic signed [SUM_W-1:0] r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]      r_wr;
    logic [FIFO_AW-1:0]      r_rd;
    logic [FIFO_CW-1:0]      r_count;

    // store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

// File: sv/mcop_front.sv
// Front end: scale each sample, accumulate the path log-return, detect path end.
module mcop_front #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [mcop_pkg::SAMPLE_W-1:0] i_sample,
    input  mcop_pkg::t_cfg                    i_cfg,
    output logic                              o_push,
    output logic signed [mcop_pkg::SUM_W-1:0] o_push_data
);
    import mcop_pkg::*;

    localparam int SEW = $clog2(MAX_STEPS + 1);
    localparam int SIW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW  = (SEW > 11) ? SEW : 11;

    logic                    r_a_valid;
    logic signed [47:0]      r_prod;
    logic signed [SUM_W-1:0] r_log;
    logic [SIW-1:0]          r_step;

    logic signed [47:0]      w_prod;
    logic signed [SUM_W-1:0] w_inc;
    logic signed [37:0]      w_sum;
    logic signed [SUM_W-1:0] w_sat;
    logic [CW-1:0]           w_sc;
    logic [SEW-1:0]          w_steps_eff;
    logic [SEW:0]            w_next_step;
    logic                    w_last;

    // scale sample by diffusion
    assign w_prod = $signed({1'b0, i_cfg.diffusion}) * i_sample;

    always_ff @(posedge i_clk) begin
        if (i_accept) r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else          r_a_valid <= i_accept;
    end

    // add drift and increment, saturate
    always_comb begin
        w_inc = SUM_W'(r_prod >>> 12);
        w_sum = 38'(r_log) + 38'(i_cfg.drift) + 38'(w_inc);
        if (w_sum > SUM_MAX)      w_sat = SUM_W'(SUM_MAX);
        else if (w_sum < SUM_MIN) w_sat = SUM_W'(SUM_MIN);
        else                      w_sat = SUM_W'(w_sum);
    end

    // clamp step count
    always_comb begin
        w_sc = CW'(i_cfg.step_count);
        if (w_sc == '0)                  w_sc = CW'(1);
        else if (w_sc > CW'(MAX_STEPS))  w_sc = CW'(MAX_STEPS);
        w_steps_eff = w_sc[SEW-1:0];
        w_next_step = (SEW+1)'(r_step) + (SEW+1)'(1);
        w_last      = (w_next_step >= {1'b0, w_steps_eff});
    end

    // hold the running sum, clear at path end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log  <= '0;
            r_step <= '0;
        end else if (r_a_valid) begin
            if (w_last) begin
                r_log  <= '0;
                r_step <= '0;
            end else begin
                r_log  <= w_sat;
                r_step <= w_next_step[SIW-1:0];
            end
        end
    end

    assign o_push      = r_a_valid && w_last;
    assign o_push_data = w_sat;

endmodule

// File: sv/mcop_back.sv
// Back end: exp of the path sum, payoffs, run sums and averages.
module mcop_back #(
    parameter int PATH_COUNT_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcop_pkg::t_cfg                    i_cfg,
    input  logic                              i_empty,
    input  logic signed [mcop_pkg::SUM_W-1:0] i_data,
    output logic                              o_pop,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [31:0]                       o_call_payoff,
    output logic [31:0]                       o_put_payoff,
    output logic [31:0]                       o_call_average,
    output logic [31:0]                       o_put_average,
    output logic                              o_is_final
);
    import mcop_pkg::*;

    localparam int PW = PATH_COUNT_BITS + 1;
    localparam int CW = (PW > 21) ? PW : 21;

    t_back_state r_state, n_state;

    logic [RED_W-1:0]     r_rem;
    logic [6:0]           r_qp;
    logic [2:0]           r_k;
    logic [59:0]          r_r60;
    logic [TERM_W-1:0]    r_term;
    logic [EXP_W-1:0]     r_e;
    logic [4:0]           r_i;
    logic [ACC_W-1:0]     r_acc;
    logic [63:0]          r_pp;
    logic [63:0]          r_divq;
    logic [4:0]           r_divr;
    logic [31:0]          r_price;
    logic [31:0]          r_call;
    logic [31:0]          r_put;
    logic [52:0]          r_call_sum;
    logic [52:0]          r_put_sum;
    logic                 r_final;
    logic [52:0]          r_dq_c;
    logic [52:0]          r_dq_p;
    logic [PW-1:0]        r_dr_c;
    logic [PW-1:0]        r_dr_p;
    logic [5:0]           r_cnt;
    logic [PATH_COUNT_BITS-1:0] r_path;

    logic                 r_out_valid;
    logic [31:0]          r_o_call;
    logic [31:0]          r_o_put;
    logic [31:0]          r_o_cavg;
    logic [31:0]          r_o_pavg;
    logic                 r_o_final;

    logic                 w_out_free;
    logic [31:0]          w_ma;
    logic [31:0]          w_mb;
    logic [RED_W-1:0]     w_x;
    logic [RED_W-1:0]     w_ln2_k;
    logic                 w_red_ge;
    logic [RED_W-1:0]     w_rem_next;
    logic [ACC_W-1:0]     w_pp_sh;
    logic [ACC_W-1:0]     w_acc_next;
    logic [63:0]          w_dq;
    logic [4:0]           w_dr;
    logic [5:0]           w_t;
    logic [6:0]           w_sh;
    logic [ACC_W-1:0]     w_v;
    logic [31:0]          w_price;
    logic [31:0]          w_diff;
    logic [32:0]          w_disc;
    logic [31:0]          w_disc_sat;
    logic                 w_is_call;
    logic [31:0]          w_call;
    logic [31:0]          w_put;
    logic [52:0]          w_csum_next;
    logic [52:0]          w_psum_next;
    logic [CW-1:0]        w_pc;
    logic [PW-1:0]        w_paths_eff;
    logic                 w_final;
    logic [PW:0]          w_tc;
    logic [PW:0]          w_tp;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == ST_IDLE) && !i_empty;

    // clamp path count
    always_comb begin
        w_pc = CW'(i_cfg.path_count);
        if (w_pc == '0)                               w_pc = CW'(1);
        else if (w_pc > (CW'(1) << PATH_COUNT_BITS))  w_pc = CW'(1) << PATH_COUNT_BITS;
        w_paths_eff = w_pc[PW-1:0];
        w_final     = (PW'(r_path) + PW'(1)) >= w_paths_eff;
    end

    // range reduction: offset by 64 ln2 so the quotient stays positive
    always_comb begin
        w_x        = {i_data[SUM_W-1], i_data, 26'd0} + RED_W'({LN2_Q56, 6'd0});
        w_ln2_k    = RED_W'(LN2_Q56) << r_k;
        w_red_ge   = (r_rem >= w_ln2_k);
        w_rem_next = w_red_ge ? (r_rem - w_ln2_k) : r_rem;
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_MUL: begin
                case (r_k)
                    3'd0:    begin w_ma = 32'(r_term[30:0]);  w_mb = 32'(r_r60[29:0]);  end
                    3'd1:    begin w_ma = 32'(r_term[30:0]);  w_mb = 32'(r_r60[59:30]); end
                    3'd2:    begin w_ma = 32'(r_term[60:31]); w_mb = 32'(r_r60[29:0]);  end
                    default: begin w_ma = 32'(r_term[60:31]); w_mb = 32'(r_r60[59:30]); end
                endcase
            end
            ST_PRICE: begin
                w_ma = i_cfg.spot;
                w_mb = (r_k == 3'd0) ? 32'(r_e[30:0]) : 32'(r_e[61:31]);
            end
            ST_PAY: begin
                w_ma = w_diff;
                w_mb = i_cfg.discount;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pp <= w_ma * w_mb;
    end

    // align the partial product that lands this cycle
    always_comb begin
        case (r_k)
            3'd1:    w_pp_sh = ACC_W'(r_pp);
            3'd2:    w_pp_sh = ACC_W'(r_pp) << 30;
            3'd3:    w_pp_sh = ACC_W'(r_pp) << 31;
            3'd4:    w_pp_sh = ACC_W'(r_pp) << 61;
            default: w_pp_sh = '0;
        endcase
        w_acc_next = r_acc + w_pp_sh;
    end

    // divide by term number, eight quotient bits per cycle
    always_comb begin
        w_dq = r_divq;
        w_dr = r_divr;
        w_t  = '0;
        for (int j = 0; j < 8; j++) begin
            w_t  = {w_dr, w_dq[63]};
            w_dq = {w_dq[62:0], 1'b0};
            if (w_t >= {1'b0, r_i}) begin
                w_dr    = 5'(w_t - {1'b0, r_i});
                w_dq[0] = 1'b1;
            end else begin
                w_dr = w_t[4:0];
            end
        end
    end

    // scale spot*exp back by 2^(60-q) and saturate
    always_comb begin
        w_sh    = 7'd124 - r_qp;
        w_v     = r_acc >> w_sh;
        w_price = (|w_v[ACC_W-1:32]) ? 32'hFFFFFFFF : w_v[31:0];
    end

    // payoff of the side in the money
    always_comb begin
        w_is_call   = r_price > i_cfg.strike;
        w_diff      = w_is_call ? (r_price - i_cfg.strike) : (i_cfg.strike - r_price);
        w_disc      = r_pp[63:31];
        w_disc_sat  = w_disc[32] ? 32'hFFFFFFFF : w_disc[31:0];
        w_call      = w_is_call ? w_disc_sat : 32'd0;
        w_put       = w_is_call ? 32'd0 : w_disc_sat;
        w_csum_next = r_call_sum + 53'(w_call);
        w_psum_next = r_put_sum + 53'(w_put);
    end

    // restoring dividers for the averages
    always_comb begin
        w_tc = {r_dr_c, r_dq_c[52]};
        w_tp = {r_dr_p, r_dq_p[52]};
    end

    // sequence one path through the back end
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_RED;
            ST_RED:   if (r_k == 3'd0) n_state = ST_MUL;
            ST_MUL:   if (r_k == 3'd4) n_state = ST_DIV;
            ST_DIV: begin
                if (r_k == 3'd7) n_state = (r_i == TAYLOR_TERMS) ? ST_PRICE : ST_MUL;
            end
            ST_PRICE: if (r_k == 3'd2) n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_PAY;
            ST_PAY:   if (r_k == 3'd1) n_state = w_final ? ST_AVG : ST_OUT;
            ST_AVG:   if (r_cnt == 6'd52) n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rem <= w_x;
                r_qp  <= '0;
                r_k   <= 3'd6;
            end
            ST_RED: begin
                r_rem <= w_rem_next;
                r_qp  <= {r_qp[5:0], w_red_ge};
                r_k   <= r_k - 1'b1;
                r_r60 <= {w_rem_next[55:0], 4'd0};
                r_term <= TERM_W'(1) << 60;
                r_e    <= EXP_W'(1) << 60;
                r_i    <= 5'd1;
                r_acc  <= '0;
            end
            ST_MUL: begin
                r_acc  <= w_acc_next;
                r_k    <= (r_k == 3'd4) ? 3'd0 : r_k + 1'b1;
                r_divq <= 64'(w_acc_next[ACC_W-1:60]);
                r_divr <= '0;
            end
            ST_DIV: begin
                r_divq <= w_dq;
                r_divr <= w_dr;
                r_k    <= r_k + 1'b1;
                if (r_k == 3'd7) begin
                    r_term <= w_dq[TERM_W-1:0];
                    r_e    <= r_e + EXP_W'(w_dq[TERM_W-1:0]);
                    r_i    <= r_i + 1'b1;
                    r_acc  <= '0;
                end
            end
            ST_PRICE: begin
                r_k <= (r_k == 3'd2) ? 3'd0 : r_k + 1'b1;
                if (r_k == 3'd1) r_acc <= ACC_W'(r_pp);
                if (r_k == 3'd2) r_acc <= r_acc + (ACC_W'(r_pp) << 31);
            end
            ST_SHIFT: begin
                r_price <= w_price;
                r_k     <= '0;
            end
            ST_PAY: begin
                r_k <= r_k + 1'b1;
                if (r_k == 3'd1) begin
                    r_call  <= w_call;
                    r_put   <= w_put;
                    r_final <= w_final;
                    r_dq_c  <= w_csum_next;
                    r_dq_p  <= w_psum_next;
                    r_dr_c  <= '0;
                    r_dr_p  <= '0;
                    r_cnt   <= '0;
                end
            end
            ST_AVG: begin
                r_cnt <= r_cnt + 1'b1;
                if (w_tc >= {1'b0, w_paths_eff}) begin
                    r_dr_c <= PW'(w_tc - {1'b0, w_paths_eff});
                    r_dq_c <= {r_dq_c[51:0], 1'b1};
                end else begin
                    r_dr_c <= w_tc[PW-1:0];
                    r_dq_c <= {r_dq_c[51:0], 1'b0};
                end
                if (w_tp >= {1'b0, w_paths_eff}) begin
                    r_dr_p <= PW'(w_tp - {1'b0, w_paths_eff});
                    r_dq_p <= {r_dq_p[51:0], 1'b1};
                end else begin
                    r_dr_p <= w_tp[PW-1:0];
                    r_dq_p <= {r_dq_p[51:0], 1'b0};
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // run sums and path counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_call_sum <= '0;
            r_put_sum  <= '0;
            r_path     <= '0;
        end else if (r_state == ST_PAY && r_k == 3'd1) begin
            r_call_sum <= w_csum_next;
            r_put_sum  <= w_psum_next;
        end else if (r_state == ST_OUT && w_out_free) begin
            if (r_final) begin
                r_call_sum <= '0;
                r_put_sum  <= '0;
                r_path     <= '0;
            end else begin
                r_path <= r_path + 1'b1;
            end
        end
    end

    // output register, freed by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_o_call  <= r_call;
            r_o_put   <= r_put;
            r_o_cavg  <= r_final ? r_dq_c[31:0] : 32'd0;
            r_o_pavg  <= r_final ? r_dq_p[31:0] : 32'd0;
            r_o_final <= r_final;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_call_payoff  = r_o_call;
    assign o_put_payoff   = r_o_put;
    assign o_call_average = r_o_cavg;
    assign o_put_average  = r_o_pavg;
    assign o_is_final     = r_o_final;

endmodule

// File: sv/monte_carlo_european_option_pricer.sv
// Top level of the Monte Carlo European option pricer.
// Usage:
//   Input channel (i_in_valid / o_in_stall) transfers one signed Q4.12 normal
//   sample per cycle, if not stalled, into the front end, which accumulates
//   the path log-return. When a path's last sample arrives, its sum goes into
//   a four-entry queue; the back end computes spot*exp(sum) by range reduction
//   and a 24-term series on one shared 32x32 multiplier, then the discounted
//   call and put payoffs. Output channel (o_out_valid / i_out_stall) transfers
//   one result per path; on the last path of a run it also carries both
//   averages and is_final. Throughput: one sample per cycle while the queue
//   has room. For each path the back end runs 7 reduction steps, 24 series
//   terms, price and payoff, plus the average dividers on the last path;
//   paths shorter than the back end's time per path fill the queue and
//   o_in_stall rises. A stalled result stays in the output register while
//   the back end goes on with the next queued path. Configuration
//   (i_cfg_valid / o_cfg_ready) is always ready; it must be written only
//   while the block is idle, and the block itself does not enforce this.
//   Reset clears all sums, counters and the queue and restores register defaults.
module monte_carlo_european_option_pricer #(
    parameter int MAX_STEPS       = 1024,
    parameter int PATH_COUNT_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_normal_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_call_payoff,
    output logic [31:0]        o_put_payoff,
    output logic [31:0]        o_call_average,
    output logic [31:0]        o_put_average,
    output logic               o_is_final,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import mcop_pkg::*;

    t_cfg                r_cfg;
    logic                w_accept;
    logic                w_push;
    logic signed [SUM_W-1:0] w_push_data;
    logic                w_pop;
    logic signed [SUM_W-1:0] w_fifo_data;
    logic                w_empty;
    logic [FIFO_CW-1:0]  w_count;
    logic                w_full;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spot       <= 32'd6553600;
            r_cfg.strike     <= 32'd6553600;
            r_cfg.drift      <= '0;
            r_cfg.diffusion  <= '0;
            r_cfg.discount   <= 32'h80000000;
            r_cfg.step_count <= 11'd100;
            r_cfg.path_count <= 21'd1024;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPOT:   r_cfg.spot       <= i_cfg_data;
                CFG_STRIKE: r_cfg.strike     <= i_cfg_data;
                CFG_DRIFT:  r_cfg.drift      <= i_cfg_data;
                CFG_DIFF:   r_cfg.diffusion  <= i_cfg_data[30:0];
                CFG_DISC:   r_cfg.discount   <= i_cfg_data;
                CFG_STEPS:  r_cfg.step_count <= i_cfg_data[10:0];
                CFG_PATHS:  r_cfg.path_count <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // keep two free slots: one sample in flight can still end a path
    assign o_in_stall = (w_count > FIFO_CW'(FIFO_DEPTH - 2));
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (w_count == FIFO_CW'(FIFO_DEPTH));

    mcop_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_sample    (i_normal_sample),
        .i_cfg       (r_cfg),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    mcop_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_fifo_data),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    mcop_back #(
        .PATH_COUNT_BITS (PATH_COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (w_empty),
        .i_data         (w_fifo_data),
        .o_pop          (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_call_payoff  (o_call_payoff),
        .o_put_payoff   (o_put_payoff),
        .o_call_average (o_call_average),
        .o_put_average  (o_put_average),
        .o_is_final     (o_is_final)
    );

    // queue never takes a path end when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full || w_pop)
        else $error("path-end queue overflow");

    // at most one payoff side is in the money
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_call_payoff == 32'd0) || (o_put_payoff == 32'd0))
        else $error("both call and put payoffs nonzero");

    // averages only on the last path of a run
    a_avg_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_final) |-> (o_call_average == 32'd0)
                                         && (o_put_average == 32'd0))
        else $error("average shown on a non-final path");

endmodule

// File: tb/sv/mcop_payoff_checker.sv
// Payoff checker for the option pricer: tracks the path state and compares every result.
module mcop_payoff_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_normal_sample,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_call_payoff,
    input  logic [31:0]        i_put_payoff,
    input  logic [31:0]        i_call_average,
    input  logic [31:0]        i_put_average,
    input  logic               i_is_final,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import mcop_pkg::*;

    localparam longint STEP_LIMIT = 1024;
    localparam longint PATH_LIMIT = 64'd1 << 20;
    localparam longint LOG_MAX    = 64'sd34359738367;
    localparam longint LOG_MIN    = -64'sd34359738368;

    typedef struct {
        logic [31:0] call_pay;
        logic [31:0] put_pay;
        logic [31:0] call_average;
        logic [31:0] put_average;
        logic        is_final;
    } t_path_payoff;

    t_path_payoff payoff_q[$];

    // model copy of the configuration
    logic [31:0]        spot, strike, discount;
    logic signed [31:0] drift;
    logic [30:0]        diffusion;
    logic [10:0]        steps_cfg;
    logic [20:0]        paths_cfg;

    // model copy of the path state
    longint      log_sum;
    longint      step_idx, path_idx;
    logic [63:0] call_total, put_total;

    // truncated Q60 product
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // spot * exp(x), x in Q30, saturated to 32 bits
    function automatic logic [31:0] gbm_price(input longint x30, input logic [31:0] s0);
        longint       ln2, x56, q, rem;
        logic [63:0]  r60, term, e;
        logic [127:0] prod, v;
        int           sh;
        ln2  = longint'({8'd0, LN2_Q56});
        x56  = x30 * 64'sd67108864;
        q    = x56 / ln2;
        rem  = x56 - q * ln2;
        if (rem < 0) begin
            rem += ln2;
            q   -= 1;
        end
        r60  = 64'(rem) << 4;
        term = 64'd1 << 60;
        e    = term;
        for (int i = 1; i <= 24; i++) begin
            term = q60_mul(term, r60) / 64'(i);
            e    += term;
        end
        prod = {96'd0, s0} * {64'd0, e};
        sh   = 60 - int'(q);
        v    = prod >> sh;
        return (v > 128'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    function automatic logic [31:0] apply_discount(input logic [31:0] diff);
        logic [63:0] v;
        v = ({32'd0, diff} * {32'd0, discount}) >> 31;
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

    // accumulate one sample; close the path when its steps are taken
    task automatic take_sample(input logic signed [15:0] smp);
        longint       prod, nsum, steps_eff, paths_eff;
        logic [31:0]  price;
        t_path_payoff r;
        prod = longint'({33'd0, diffusion}) * longint'(smp);
        nsum = log_sum + longint'(drift) + (prod >>> 12);
        if (nsum > LOG_MAX) nsum = LOG_MAX;
        if (nsum < LOG_MIN) nsum = LOG_MIN;
        log_sum = nsum;
        steps_eff = (steps_cfg == 0) ? 1 : longint'(steps_cfg);
        if (steps_eff > STEP_LIMIT) steps_eff = STEP_LIMIT;
        if (step_idx + 1 < steps_eff) begin
            step_idx++;
            return;
        end
        price = gbm_price(log_sum, spot);
        r.call_pay = (price > strike) ? apply_discount(price - strike) : 32'd0;
        r.put_pay  = (strike > price) ? apply_discount(strike - price) : 32'd0;
        log_sum  = 0;
        step_idx = 0;
        call_total += {32'd0, r.call_pay};
        put_total  += {32'd0, r.put_pay};
        paths_eff = (paths_cfg == 0) ? 1 : longint'(paths_cfg);
        if (paths_eff > PATH_LIMIT) paths_eff = PATH_LIMIT;
        r.is_final = (path_idx + 1 >= paths_eff);
        if (r.is_final) begin
            r.call_average = 32'(call_total / 64'(paths_eff));
            r.put_average  = 32'(put_total / 64'(paths_eff));
            call_total = 0;
            put_total  = 0;
            path_idx   = 0;
        end else begin
            r.call_average = 0;
            r.put_average  = 0;
            path_idx++;
        end
        payoff_q.insert(payoff_q.size(), r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // watch the channels at every edge
    always @(posedge i_clk) begin
        t_path_payoff r;
        if (!i_rst_n) begin
            spot       <= 32'd6553600;
            strike     <= 32'd6553600;
            drift      <= 32'sd0;
            diffusion  <= 31'd0;
            discount   <= 32'h80000000;
            steps_cfg  <= 11'd100;
            paths_cfg  <= 21'd1024;
            log_sum    = 0;
            step_idx   = 0;
            path_idx   = 0;
            call_total = 0;
            put_total  = 0;
            o_fail_count = 0;
            payoff_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPOT:   spot      <= i_cfg_data;
                    CFG_STRIKE: strike    <= i_cfg_data;
                    CFG_DRIFT:  drift     <= i_cfg_data;
                    CFG_DIFF:   diffusion <= i_cfg_data[30:0];
                    CFG_DISC:   discount  <= i_cfg_data;
                    CFG_STEPS:  steps_cfg <= i_cfg_data[10:0];
                    CFG_PATHS:  paths_cfg <= i_cfg_data[20:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                take_sample(i_normal_sample);
            if (i_out_valid && !i_out_stall) begin
                if (payoff_q.size() == 0) begin
                    $error("result transfer with no result expected");
                    o_fail_count++;
                end else begin
                    r = payoff_q.pop_front();
                    check_field("o_call_payoff", r.call_pay, i_call_payoff);
                    check_field("o_put_payoff", r.put_pay, i_put_payoff);
                    check_field("call_average", r.call_average, i_call_average);
                    check_field("put_average", r.put_average, i_put_average);
                    check_field("is_final", {31'd0, r.is_final}, {31'd0, i_is_final});
                end
            end
        end
        o_pending = payoff_q.size();
    end

endmodule

// File: tb/sv/tb_monte_carlo_european_option_pricer.sv
// Testbench top for the option pricer: stimulus, register phases and verdict.
module tb_monte_carlo_european_option_pricer;
    import mcop_pkg::*;

    localparam logic [2:0] UNMAPPED_IDX = 3'd7;
    localparam int         DRAIN_CYCLES = 400;

    // idle patterns
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_normal_sample = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [31:0]        o_call_payoff, o_put_payoff, o_call_average, o_put_average;
    logic               o_is_final;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    int fail_count, pending;
    int idle_mode = MODE_NONE;
    int samples_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    monte_carlo_european_option_pricer dut (.*);

    mcop_payoff_checker u_payoff_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_normal_sample,
        .i_out_valid(o_out_valid), .i_out_stall, .i_call_payoff(o_call_payoff),
        .i_put_payoff(o_put_payoff), .i_call_average(o_call_average),
        .i_put_average(o_put_average), .i_is_final(o_is_final), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        case (idle_mode)
            MODE_RECV: i_out_stall <= ($urandom_range(99) < 59);
            MODE_BOTH: i_out_stall <= ($urandom_range(99) < 19);
            default:   i_out_stall <= 1'b0;
        endcase
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one sample transfer, with optional sender gaps
    task automatic send_sample();
        int gap_pct;
        logic signed [15:0] smp;
        gap_pct = (idle_mode == MODE_SEND) ? 59 : (idle_mode == MODE_BOTH) ? 19 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        case ($urandom_range(11))
            0:       smp = 16'sh7FFF;
            1:       smp = -16'sh8000;
            2:       smp = 16'sd0;
            3:       smp = -16'sd1;
            default: smp = 16'($urandom);
        endcase
        i_in_valid      <= 1'b1;
        i_normal_sample <= smp;
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
    endtask

    // let the checker see the last transfer, wait out every result, then settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [31:0] spot, input logic [31:0] strike,
                             input logic [31:0] drift, input logic [31:0] diff,
                             input logic [31:0] disc, input logic [31:0] steps,
                             input logic [31:0] paths, input int count, input int mode);
        cfg_write(CFG_SPOT, spot);
        cfg_write(CFG_STRIKE, strike);
        cfg_write(CFG_DRIFT, drift);
        cfg_write(CFG_DIFF, diff);
        cfg_write(CFG_DISC, disc);
        cfg_write(CFG_STEPS, steps);
        cfg_write(CFG_PATHS, paths);
        cfg_write(UNMAPPED_IDX, $urandom);
        idle_mode = mode;
        repeat (count) send_sample();
        drain();
    endtask

    initial begin
        int phase;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // top drift and diffusion, one step per path
        run_phase(32'd6553600, 32'd6553600, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                  1, 3, 5, MODE_NONE);
        // zero spot, top strike, zero counts, discount above one
        run_phase(32'd0, 32'hFFFFFFFF, 32'h80000000, 32'd0, 32'hFFFFFFFF,
                  0, 0, 4, MODE_NONE);
        // top spot, zero strike: call in the money
        run_phase(32'hFFFFFFFF, 32'd0, 32'd0, 32'h10000000, 32'hFFFFFFFF,
                  1, 2, 4, MODE_NONE);
        // leave a path half done, then lower the step count under it
        run_phase(32'd6553600, 32'd7000000, 32'h00100000, 32'h04000000, 32'h7F000000,
                  5, 3, 3, MODE_NONE);
        run_phase(32'd6553600, 32'd6000000, 32'hFFF00000, 32'h04000000, 32'd0,
                  2, 1, 4, MODE_NONE);
        // step and path counts above their limits; the path stays open
        run_phase(32'd6553600, 32'd6553600, 32'd0, 32'h00400000, 32'h80000000,
                  32'h7FF, 32'h1FFFFF, 200, MODE_NONE);

        // random settings, cycling the idle patterns
        phase = 0;
        while (samples_sent < 650) begin
            run_phase($urandom_range(50 << 16, 150 << 16), $urandom_range(50 << 16, 150 << 16),
                      $urandom_range(0, 1 << 24) - (1 << 23), $urandom_range(0, 1 << 28),
                      $urandom_range(1 << 30, 1 << 31), $urandom_range(1, 6),
                      $urandom_range(1, 4), $urandom_range(10, 60), phase % 4);
            phase++;
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
